// ===== rtl/earliest_free_worker_scheduler_top_defines.svh =====
// assertion macros for the earliest free worker scheduler
`ifndef EARLIEST_FREE_WORKER_SCHEDULER_TOP_DEFINES_SVH
`define EARLIEST_FREE_WORKER_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define EFWS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// next-cycle implication
`define EFWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// ===== rtl/efws_pkg.sv =====
// shared types, constants and functions of the earliest free worker scheduler
`timescale 1ns / 1ps
`default_nettype none

package efws_pkg;

   localparam int MaxWorkers = 16;
   localparam int TimeBits   = 48;
   localparam int DurBits    = 32;
   localparam int WorkerBits = 4;
   localparam int IdxBits    = $clog2(MaxWorkers);
   localparam int CountBits  = $clog2(MaxWorkers + 1);
   localparam int ChildBits  = IdxBits + 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_CMP,
      ST_LAST
   } state_type;

   typedef struct packed {
      logic [TimeBits-1:0] free_time;
      logic [IdxBits-1:0]  worker;
   } entry_type;

   typedef struct packed {
      logic [WorkerBits-1:0] worker_index;
      logic [TimeBits-1:0]   start_time;
   } result_type;

   typedef struct packed {
      logic      take_right;
      logic      swap;
      entry_type child;
   } sel_type;

   function automatic logic [TimeBits-1:0] sat_add(input logic [TimeBits-1:0] t,
                                                    input logic [DurBits-1:0] d);
      logic [TimeBits:0] s;
      begin
         s = {1'b0, t} + (TimeBits+1)'(d);
         if (s[TimeBits]) begin
            sat_add = '1;
         end else begin
            sat_add = s[TimeBits-1:0];
         end
      end
   endfunction

   function automatic logic [CountBits-1:0] clamp_count(input logic [CountBits-1:0] v);
      begin
         if (v == '0) begin
            clamp_count = CountBits'(1);
         end else if (v > CountBits'(MaxWorkers)) begin
            clamp_count = CountBits'(MaxWorkers);
         end else begin
            clamp_count = v;
         end
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/efws_child_sel.sv =====
// picks the smaller child of a heap node and decides whether it moves up
`timescale 1ns / 1ps
`default_nettype none

module efws_child_sel (
   input  efws_pkg::entry_type left_entry,
   input  efws_pkg::entry_type right_entry,
   input  logic                right_ok,
   input  efws_pkg::entry_type cur_entry,
   output efws_pkg::sel_type   sel
);

   logic right_less;

   always_comb begin
      right_less     = right_ok && (right_entry < left_entry);
      sel.take_right = right_less;
      sel.child      = right_less ? right_entry : left_entry;
      sel.swap       = sel.child < cur_entry;
   end

endmodule

`default_nettype wire

// ===== rtl/efws_heap_ctrl.sv =====
// heap memory and sift-down sequencer of the earliest free worker scheduler
`timescale 1ns / 1ps
`default_nettype none

module efws_heap_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 clear,
   input  logic [efws_pkg::CountBits-1:0]       heap_size,
   input  logic                                 start_valid,
   output logic                                 start_ready,
   input  logic [efws_pkg::DurBits-1:0]         duration,
   input  logic                                 out_free,
   output logic                                 emit,
   output efws_pkg::result_type                 result
);

   efws_pkg::state_type state_ff, state_in;
   logic [efws_pkg::DurBits-1:0] dur_ff, dur_in;
   efws_pkg::entry_type cur_ff, cur_in;
   logic [efws_pkg::IdxBits-1:0] pos_ff, pos_in;
   logic [efws_pkg::MaxWorkers-1:0] valid_ff;

   efws_pkg::entry_type mem [efws_pkg::MaxWorkers];
   efws_pkg::entry_type rd_a_ff, rd_b_ff;
   logic [efws_pkg::IdxBits-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic rb_ok_ff, rb_ok_in;

   logic rd_en, wr_en;
   logic [efws_pkg::IdxBits-1:0] wr_addr;
   efws_pkg::entry_type wr_data;

   efws_pkg::entry_type ent_a, ent_b, new_root;
   efws_pkg::sel_type sel;
   logic [efws_pkg::IdxBits-1:0] best_addr, nxt_pos;
   logic [efws_pkg::IdxBits:0] left_addr;
   logic [efws_pkg::ChildBits-1:0] right_addr;
   logic left_ok, right_ok;

   // entries never written since clear read as their initial value
   always_comb begin
      ent_a = valid_ff[ra_ff] ? rd_a_ff : efws_pkg::entry_type'{free_time: '0, worker: ra_ff};
      ent_b = valid_ff[rb_ff] ? rd_b_ff : efws_pkg::entry_type'{free_time: '0, worker: rb_ff};
   end

   efws_child_sel u_child_sel (
      .left_entry  (ent_a),
      .right_entry (ent_b),
      .right_ok    (rb_ok_ff),
      .cur_entry   (cur_ff),
      .sel         (sel)
   );

   always_comb begin
      result.worker_index = efws_pkg::WorkerBits'(ent_a.worker);
      result.start_time   = ent_a.free_time;
      new_root.free_time  = efws_pkg::sat_add(ent_a.free_time, dur_ff);
      new_root.worker     = ent_a.worker;
      best_addr  = sel.take_right ? rb_ff : ra_ff;
      nxt_pos    = (state_ff == efws_pkg::ST_CMP) ? best_addr : '0;
      left_addr  = {nxt_pos, 1'b1};
      right_addr = efws_pkg::ChildBits'(left_addr) + efws_pkg::ChildBits'(1);
      left_ok    = efws_pkg::ChildBits'(left_addr) < efws_pkg::ChildBits'(heap_size);
      right_ok   = right_addr < efws_pkg::ChildBits'(heap_size);
   end

   always_comb begin
      state_in    = state_ff;
      dur_in      = dur_ff;
      cur_in      = cur_ff;
      pos_in      = pos_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rb_ok_in    = rb_ok_ff;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = pos_ff;
      wr_data     = cur_ff;
      emit        = 1'b0;
      start_ready = 1'b0;
      unique case (state_ff)
         efws_pkg::ST_IDLE: begin
            start_ready = 1'b1;
            if (start_valid) begin
               dur_in   = duration;
               rd_en    = 1'b1;
               ra_in    = '0;
               state_in = efws_pkg::ST_ROOT;
            end
         end
         efws_pkg::ST_ROOT: begin
            if (out_free) begin
               emit   = 1'b1;
               cur_in = new_root;
               pos_in = '0;
               if (left_ok) begin
                  rd_en    = 1'b1;
                  ra_in    = left_addr[efws_pkg::IdxBits-1:0];
                  rb_in    = right_addr[efws_pkg::IdxBits-1:0];
                  rb_ok_in = right_ok;
                  state_in = efws_pkg::ST_CMP;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = new_root;
                  state_in = efws_pkg::ST_IDLE;
               end
            end
         end
         efws_pkg::ST_CMP: begin
            wr_en = 1'b1;
            if (sel.swap) begin
               wr_data = sel.child;
               pos_in  = best_addr;
               if (left_ok) begin
                  rd_en    = 1'b1;
                  ra_in    = left_addr[efws_pkg::IdxBits-1:0];
                  rb_in    = right_addr[efws_pkg::IdxBits-1:0];
                  rb_ok_in = right_ok;
               end else begin
                  state_in = efws_pkg::ST_LAST;
               end
            end else begin
               state_in = efws_pkg::ST_IDLE;
            end
         end
         efws_pkg::ST_LAST: begin
            wr_en    = 1'b1;
            state_in = efws_pkg::ST_IDLE;
         end
         default: begin
            state_in = efws_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff   <= dur_in;
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      ra_ff    <= ra_in;
      rb_ff    <= rb_in;
      rb_ok_ff <= rb_ok_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[ra_in];
         rd_b_ff <= mem[rb_in];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/earliest_free_worker_scheduler_top.sv =====
// top level of the earliest free worker scheduler
// Each job on req_ goes to the worker that frees up earliest (lowest index on a
// tie); rsp_ returns that worker and the job's start time, and the worker's free
// time becomes start plus duration, saturating at the 48-bit maximum. The heap of
// (free time, worker) pairs lives in a 16-entry memory with two read ports and one
// write port; a job is accepted in the idle state, the root read and the result
// follow, then one read-compare-write step per heap level descended and possibly
// a final write; req_ready is high only in the idle state, so a new job waits for
// the sift-down through that memory to end. The root step also waits while the
// previous result is still held on rsp_.
// Writing csr_wr_data (clamped to 1..16) sets the worker count and resets every
// free time to zero; write it only while no job is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "earliest_free_worker_scheduler_top_defines.svh"

module earliest_free_worker_scheduler_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [efws_pkg::DurBits-1:0]       req_job_duration,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [efws_pkg::WorkerBits-1:0]    rsp_worker_index,
   output logic [efws_pkg::TimeBits-1:0]      rsp_start_time,
   input  logic                               csr_wr_en,
   input  logic [efws_pkg::CountBits-1:0]     csr_wr_data
);

   logic [efws_pkg::CountBits-1:0] worker_count_ff;
   logic rsp_valid_ff;
   efws_pkg::result_type rsp_ff;
   efws_pkg::result_type result;
   logic emit, out_free;
   logic count_ok;

   assign out_free = !rsp_valid_ff || rsp_ready;

   efws_heap_ctrl u_heap_ctrl (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_wr_en),
      .heap_size   (worker_count_ff),
      .start_valid (req_valid),
      .start_ready (req_ready),
      .duration    (req_job_duration),
      .out_free    (out_free),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         worker_count_ff <= efws_pkg::CountBits'(1);
      end else if (csr_wr_en) begin
         worker_count_ff <= efws_pkg::clamp_count(csr_wr_data);
      end
   end

   // output register, refilled when empty or on the transfer cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_worker_index = rsp_ff.worker_index;
   assign rsp_start_time   = rsp_ff.start_time;

   assign count_ok = (worker_count_ff != '0) &&
                     (worker_count_ff <= efws_pkg::CountBits'(efws_pkg::MaxWorkers));

   `EFWS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `EFWS_ASSERT_NEXT(a_emit_fills_rsp, clock, reset, emit, rsp_valid_ff)
   `EFWS_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ok)

endmodule

`default_nettype wire

// ===== sim/earliest_free_worker_scheduler_checker.sv =====
// checker that predicts and compares worker assignments of the scheduler
`timescale 1ns / 1ps

module earliest_free_worker_scheduler_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [efws_pkg::DurBits-1:0]      req_job_duration,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [efws_pkg::WorkerBits-1:0]   rsp_worker_index,
   input  logic [efws_pkg::TimeBits-1:0]     rsp_start_time,
   input  logic                              csr_wr_en,
   input  logic [efws_pkg::CountBits-1:0]    csr_wr_data,
   output int                                fail_count,
   output int                                pending_count
);

   logic [efws_pkg::TimeBits-1:0] worker_free_at [efws_pkg::MaxWorkers];
   int unsigned                   workers_active;
   efws_pkg::result_type          expected_assignments [$];
   int                            mismatches = 0;

   function automatic logic [efws_pkg::TimeBits-1:0] busy_until(
      input logic [efws_pkg::TimeBits-1:0] start,
      input logic [efws_pkg::DurBits-1:0]  dur);
      logic [efws_pkg::TimeBits:0] total;
      begin
         total = {1'b0, start} +
                 {{(efws_pkg::TimeBits + 1 - efws_pkg::DurBits){1'b0}}, dur};
         busy_until = total[efws_pkg::TimeBits] ? {efws_pkg::TimeBits{1'b1}} :
                                                  total[efws_pkg::TimeBits-1:0];
      end
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      efws_pkg::result_type want;
      int                   best;
      if (reset) begin
         workers_active = 1;
         for (int i = 0; i < efws_pkg::MaxWorkers; i++) begin
            worker_free_at[i] = '0;
         end
         expected_assignments.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data == '0) begin
               workers_active = 1;
            end else if (csr_wr_data > efws_pkg::CountBits'(efws_pkg::MaxWorkers)) begin
               workers_active = efws_pkg::MaxWorkers;
            end else begin
               workers_active = 32'(csr_wr_data);
            end
            for (int i = 0; i < efws_pkg::MaxWorkers; i++) begin
               worker_free_at[i] = '0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_assignments.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected rsp transfer, expected none actual worker %0d %s %0d",
                        $time, rsp_worker_index, "start", rsp_start_time);
            end else begin
               want = expected_assignments.pop_front();
               if (rsp_worker_index !== want.worker_index) begin
                  note_mismatch("worker_index", 64'(want.worker_index),
                                64'(rsp_worker_index));
               end
               if (rsp_start_time !== want.start_time) begin
                  note_mismatch("start_time", 64'(want.start_time), 64'(rsp_start_time));
               end
            end
         end
         if (req_valid && req_ready) begin
            best = 0;
            // strict compare keeps the lowest index on a tie
            for (int i = 1; i < workers_active; i++) begin
               if (worker_free_at[i] < worker_free_at[best]) begin
                  best = i;
               end
            end
            want.worker_index = efws_pkg::WorkerBits'(best);
            want.start_time   = worker_free_at[best];
            worker_free_at[best] = busy_until(worker_free_at[best], req_job_duration);
            expected_assignments.push_back(want);
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_assignments.size();
   end

endmodule

// ===== sim/earliest_free_worker_scheduler_top_tb.sv =====
// testbench top that drives jobs and worker counts into the scheduler
`timescale 1ns / 1ps

module earliest_free_worker_scheduler_top_tb;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_ready;
   logic [efws_pkg::DurBits-1:0]      req_job_duration;
   logic                              rsp_valid;
   logic                              rsp_ready;
   logic [efws_pkg::WorkerBits-1:0]   rsp_worker_index;
   logic [efws_pkg::TimeBits-1:0]     rsp_start_time;
   logic                              csr_wr_en;
   logic [efws_pkg::CountBits-1:0]    csr_wr_data;
   int                                fail_count;
   int                                pending_count;
   bit                                idle_on;
   bit                                hold_rsp;

   earliest_free_worker_scheduler_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_job_duration (req_job_duration),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_worker_index (rsp_worker_index),
      .rsp_start_time   (rsp_start_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   earliest_free_worker_scheduler_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_job_duration (req_job_duration),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_worker_index (rsp_worker_index),
      .rsp_start_time   (rsp_start_time),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   // one job transfer, with an optional idle burst in front
   task automatic push_job(input logic [efws_pkg::DurBits-1:0] dur);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_job_duration = dur;
      do @(posedge clock); while (!req_ready);
   endtask

   // no result pending and the sift-down finished
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0 || !req_ready) @(negedge clock);
   endtask

   task automatic set_workers(input logic [efws_pkg::CountBits-1:0] n);
      wait_drained();
      csr_wr_en   = 1'b1;
      csr_wr_data = n;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // receiver side
   initial begin
      int gap;
      rsp_ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (150) @(negedge clock);
            hold_rsp  = 1'b0;
            rsp_ready = 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      logic [efws_pkg::DurBits-1:0] dur;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_job_duration = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      idle_on          = 1'b0;
      hold_rsp         = 1'b0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // reset worker count of one
      push_job('0);
      push_job(efws_pkg::DurBits'(5));
      push_job('1);
      push_job(efws_pkg::DurBits'(1));

      // all workers tie at zero
      set_workers(efws_pkg::CountBits'(16));
      push_job('0);
      push_job('0);
      push_job(efws_pkg::DurBits'(10));
      push_job(efws_pkg::DurBits'(3));
      push_job(efws_pkg::DurBits'(3));
      push_job(efws_pkg::DurBits'(7));
      push_job(efws_pkg::DurBits'(1));
      push_job('1);

      // zero clamps to one worker
      set_workers('0);
      push_job(efws_pkg::DurBits'(9));
      push_job(efws_pkg::DurBits'(2));

      // above the maximum clamps to sixteen, then two workers
      set_workers('1);
      push_job(efws_pkg::DurBits'(4));
      push_job(efws_pkg::DurBits'(4));
      push_job('0);
      set_workers(efws_pkg::CountBits'(17));
      push_job(efws_pkg::DurBits'(100));
      push_job(efws_pkg::DurBits'(1));
      set_workers(efws_pkg::CountBits'(2));
      push_job(efws_pkg::DurBits'(6));
      push_job(efws_pkg::DurBits'(6));
      push_job(efws_pkg::DurBits'(6));

      // single worker with the longest durations
      set_workers(efws_pkg::CountBits'(1));
      repeat (4) push_job('1);
      push_job('0);
      push_job(efws_pkg::DurBits'(7));
      push_job('1);

      for (int phase = 0; phase < 10; phase++) begin
         case ($urandom_range(0, 5))
            0: set_workers(efws_pkg::CountBits'(1));
            1: set_workers(efws_pkg::CountBits'(16));
            2: set_workers(efws_pkg::CountBits'($urandom_range(16, 31)));
            default: set_workers(efws_pkg::CountBits'($urandom_range(2, 15)));
         endcase
         idle_on = (phase < 7) && (phase % 3 != 2);
         if (phase == 1) begin
            set_workers(efws_pkg::CountBits'(16));
            hold_rsp = 1'b1;
         end
         repeat (60) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: dur = efws_pkg::DurBits'($urandom_range(0, 15));
               4, 5:       dur = efws_pkg::DurBits'($urandom_range(0, 1000));
               6, 7:       dur = $urandom;
               8:          dur = '1;
               default:    dur = '0;
            endcase
            push_job(dur);
         end
      end

      idle_on = 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/efws_pkg.sv
rtl/efws_child_sel.sv
rtl/efws_heap_ctrl.sv
rtl/earliest_free_worker_scheduler_top.sv
sim/earliest_free_worker_scheduler_checker.sv
sim/earliest_free_worker_scheduler_top_tb.sv
